// ----- design/bqeq_pkg.sv -----
`default_nettype none
package bqeq_pkg;

  localparam int NUM_SECTIONS_DEF = 3;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 24;

  // Coefficients per section: b0, b1, b2, a1, a2.
  localparam int TAPS = 5;

  // Tap codes, in the order the coefficients sit in the table.
  localparam logic [2:0] TAP_B0 = 3'd0;
  localparam logic [2:0] TAP_B1 = 3'd1;
  localparam logic [2:0] TAP_B2 = 3'd2;
  localparam logic [2:0] TAP_A1 = 3'd3;
  localparam logic [2:0] TAP_A2 = 3'd4;

  // Step counter values inside one section: five issues, two to drain.
  localparam logic [2:0] STEP_ACC_FIRST = 3'd2;
  localparam logic [2:0] STEP_ACC_NEG   = 3'd5;
  localparam logic [2:0] STEP_LAST      = 3'd6;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_MAC,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic acc_clr;
    logic acc_en;
    logic acc_neg;
  } mac_ctl_t;

endpackage
`default_nettype wire

// ----- design/bqeq_ram.sv -----
`default_nettype none
module bqeq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 15,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- design/bqeq_mac.sv -----
`default_nettype none
module bqeq_mac #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  wire logic                           clk,
  input  wire bqeq_pkg::mac_ctl_t             ctl,
  input  wire logic signed [COEF_WIDTH-1:0]   coef,
  input  wire logic signed [SAMPLE_WIDTH-1:0] operand,
  output logic             [SAMPLE_WIDTH-1:0] y
);
  import bqeq_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  // Five products need two guard bits; at the widest settings the sum wraps at 64 bits.
  localparam int ACC_W  = (PROD_W + 2 > 64) ? 64 : PROD_W + 2;
  localparam int SH     = COEF_WIDTH - 4;
  localparam int RES_W  = ACC_W - SH;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_WIDTH - 5);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  sum;
  logic        [RES_W-1:0]  res;
  logic                     in_range;

  assign prod_ext = ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(coef) * PROD_W'(operand);
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= ctl.acc_neg ? acc_r - prod_ext : acc_r + prod_ext;
    end
  end

  // Round half up, drop the fraction, then clip to the sample range.
  assign sum      = acc_r + RND;
  assign res      = sum[ACC_W-1:SH];
  assign in_range = (res[RES_W-1:SAMPLE_WIDTH-1] == '0) ||
                    (res[RES_W-1:SAMPLE_WIDTH-1] == '1);

  always_comb begin
    if (in_range) begin
      y = res[SAMPLE_WIDTH-1:0];
    end else if (res[RES_W-1]) begin
      y = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

// ----- design/biquad_cascade_equalizer_unit.sv -----
`default_nettype none
// Channel   Dir  Signals                          Carries
// in        in   in_tvalid/in_tready/in_tdata     filter or coefficient request
//                in_tuser                         op
// out       out  out_tvalid/out_tready/out_tdata  filtered sample
// cfg       in   cfg_we/cfg_wdata                 section_enable
//
// A coefficient request is taken and the block stays ready.
// A sample keeps the block busy until it has passed every enabled section, skipping
// bypassed ones, and its result is in the result register; the single multiplier,
// fed one tap a cycle by a two-stage read and multiply pipeline, sets the pace.
// The result register lets the next request in while the last sample waits.
// Synchronous reset clears the enables and histories; coefficients then read zero.
module biquad_cascade_equalizer_unit #(
  parameter int NUM_SECTIONS = bqeq_pkg::NUM_SECTIONS_DEF,
  parameter int SAMPLE_WIDTH = bqeq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bqeq_pkg::COEF_WIDTH_DEF,
  localparam int NCOEF       = NUM_SECTIONS * bqeq_pkg::TAPS,
  localparam int CAW         = $clog2(NCOEF),
  localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + CAW + COEF_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // sample_in, coef_index, coef_value, zero padding
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,
  // op
  input  wire logic [0:0]              in_tuser,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // sample_out, zero padding
  output logic      [OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                    cfg_we,
  input  wire logic [NUM_SECTIONS-1:0] cfg_wdata
);
  import bqeq_pkg::*;

  localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

  state_t state_r, state_nxt;

  logic [NUM_SECTIONS-1:0] en_r;
  logic [SEC_W-1:0]        sec_r;
  logic [2:0]              step_r;
  logic [SAMPLE_WIDTH-1:0] v_r;
  logic [SAMPLE_WIDTH-1:0] xh1_r [NUM_SECTIONS];
  logic [SAMPLE_WIDTH-1:0] xh2_r [NUM_SECTIONS];
  logic [SAMPLE_WIDTH-1:0] yh1_r [NUM_SECTIONS];
  logic [SAMPLE_WIDTH-1:0] yh2_r [NUM_SECTIONS];
  logic [NCOEF-1:0]        coef_vld_r;
  logic                    cvld_r;
  logic [SAMPLE_WIDTH-1:0] opnd_r;
  logic                    out_tvalid_r;
  logic [SAMPLE_WIDTH-1:0] out_data_r;

  logic [SAMPLE_WIDTH-1:0] in_sample;
  logic [CAW-1:0]          in_index;
  logic [COEF_WIDTH-1:0]   in_coef;
  logic                    in_acc;
  logic                    coef_we;
  logic                    last_sec;
  logic                    sec_on;
  logic                    out_free;
  logic [2:0]              tap;
  logic [CAW-1:0]          raddr;
  logic [COEF_WIDTH-1:0]   rdata;
  logic [COEF_WIDTH-1:0]   coef_op;
  logic [SAMPLE_WIDTH-1:0] opnd_sel;
  logic [SAMPLE_WIDTH-1:0] y_sec;
  mac_ctl_t                mac_ctl;

  assign in_sample = in_tdata[SAMPLE_WIDTH-1:0];
  assign in_index  = in_tdata[SAMPLE_WIDTH+CAW-1:SAMPLE_WIDTH];
  assign in_coef   = in_tdata[SAMPLE_WIDTH+CAW+COEF_WIDTH-1:SAMPLE_WIDTH+CAW];

  assign in_acc   = in_tvalid && in_tready;
  assign coef_we  = in_acc && (in_tuser[0] == OP_COEF) &&
                    ((CAW+1)'(in_index) < (CAW+1)'(NCOEF));
  assign last_sec = (sec_r == SEC_W'(NUM_SECTIONS - 1));
  assign sec_on   = en_r[sec_r];
  assign out_free = !out_tvalid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser[0] == OP_FILTER)) begin
          state_nxt = ST_SEC;
        end
      end
      ST_SEC: begin
        if (sec_on) begin
          state_nxt = ST_MAC;
        end else if (last_sec) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MAC: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = last_sec ? ST_DONE : ST_SEC;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready       = (state_r == ST_IDLE);
    mac_ctl.acc_clr = (state_r == ST_SEC);
    mac_ctl.acc_en  = (state_r == ST_MAC) && (step_r >= STEP_ACC_FIRST);
    mac_ctl.acc_neg = (step_r >= STEP_ACC_NEG);
  end

  // During the drain steps the read address stays inside the section.
  assign tap   = (step_r <= TAP_A2) ? step_r : TAP_B0;
  assign raddr = CAW'(sec_r) * CAW'(TAPS) + CAW'(tap);

  always_comb begin
    case (tap)
      TAP_B0:  opnd_sel = v_r;
      TAP_B1:  opnd_sel = xh1_r[sec_r];
      TAP_B2:  opnd_sel = xh2_r[sec_r];
      TAP_A1:  opnd_sel = yh1_r[sec_r];
      TAP_A2:  opnd_sel = yh2_r[sec_r];
      default: opnd_sel = '0;
    endcase
  end

  // A coefficient never written since reset reads as zero.
  assign coef_op = cvld_r ? rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      en_r         <= '0;
      coef_vld_r   <= '0;
      out_tvalid_r <= 1'b0;
      sec_r        <= '0;
      step_r       <= '0;
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        xh1_r[i] <= '0;
        xh2_r[i] <= '0;
        yh1_r[i] <= '0;
        yh2_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
      if (coef_we) begin
        coef_vld_r[in_index] <= 1'b1;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          sec_r <= '0;
        end
        ST_SEC: begin
          step_r <= '0;
          if (!sec_on && !last_sec) begin
            sec_r <= sec_r + SEC_W'(1);
          end
        end
        ST_MAC: begin
          step_r <= step_r + 3'd1;
        end
        ST_ROUND: begin
          xh2_r[sec_r] <= xh1_r[sec_r];
          xh1_r[sec_r] <= v_r;
          yh2_r[sec_r] <= yh1_r[sec_r];
          yh1_r[sec_r] <= y_sec;
          if (!last_sec) begin
            sec_r <= sec_r + SEC_W'(1);
          end
        end
        default: begin
          sec_r <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cvld_r <= coef_vld_r[raddr];
    opnd_r <= opnd_sel;
    if (in_acc) begin
      v_r <= in_sample;
    end else if (state_r == ST_ROUND) begin
      v_r <= y_sec;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= v_r;
    end
  end

  bqeq_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (NCOEF)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (in_index),
    .wdata (in_coef),
    .raddr (raddr),
    .rdata (rdata)
  );

  bqeq_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .coef    (coef_op),
    .operand (opnd_r),
    .y       (y_sec)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule
`default_nettype wire

// ----- design/bqeq_chk.sv -----
`default_nettype none
module bqeq_chk #(
  parameter int SAMPLE_WIDTH = bqeq_pkg::SAMPLE_WIDTH_DEF,
  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_tvalid,
  input wire logic                    in_tready,
  input wire logic [0:0]              in_tuser,
  input wire logic                    out_tvalid,
  input wire logic                    out_tready,
  input wire logic [OUT_TDATA_W-1:0]  out_tdata
);
  import bqeq_pkg::*;

  // Nothing is presented on the result side straight after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result presented after reset");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A sample request occupies the block.
  a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == OP_FILTER) |=> !in_tready)
    else $error("ready held through a sample");

  // A coefficient request completes at once.
  a_coef_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == OP_COEF) |=> in_tready)
    else $error("coefficient write stalled the block");

  // A new result only comes out of sample work.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

endmodule

bind biquad_cascade_equalizer_unit bqeq_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqeq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
